// ===== design/erv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erv_pkg
// Shared constants and types for the Euler angle point rotation pipeline.
// ----------------------------------------------------------------------------
package erv_pkg;

  // Sine and cosine are signed Q1.16 values.
  localparam int TRIG_W      = 18;
  localparam int TRIG_FRAC   = 16;
  localparam int TRIG_ONE    = 65536;

  // CORDIC datapath: 32-bit phase, Q3.30 vector, 24 micro-rotations.
  localparam int CORDIC_W       = 34;
  localparam int PHASE_W        = 32;
  localparam int CORDIC_STEPS   = 24;
  localparam int STEPS_PER_STG  = 4;
  localparam int CORDIC_STG     = CORDIC_STEPS / STEPS_PER_STG;
  localparam int CORDIC_GAIN    = 652032874;
  localparam int CORDIC_RND     = 8192;
  localparam int CORDIC_SHIFT   = 14;

  typedef logic signed [TRIG_W-1:0]   trig_t;
  typedef logic signed [CORDIC_W-1:0] cordic_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam logic signed [CORDIC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

endpackage

// ===== design/erv_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erv_cordic
// Pipelined CORDIC sine and cosine of a binary angle.
// ----------------------------------------------------------------------------
module erv_cordic import erv_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output trig_t                  sin_val,
  output trig_t                  cos_val
);

  logic [PHASE_W-1:0] phase;
  logic               neg_in;
  cordic_t            x_r [CORDIC_STG+1];
  cordic_t            y_r [CORDIC_STG+1];
  cordic_t            z_r [CORDIC_STG+1];
  logic               neg_r [CORDIC_STG+1];
  trig_t              sin_r, cos_r;
  trig_t              sin_nxt, cos_nxt;

  // Fold the second and third quadrants onto the first and fourth.
  assign phase  = PHASE_W'(angle) << (PHASE_W - ANGLE_WIDTH);
  assign neg_in = phase[PHASE_W-1] ^ phase[PHASE_W-2];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= CORDIC_W'(CORDIC_GAIN);
      y_r[0]   <= '0;
      z_r[0]   <= CORDIC_W'($signed({~neg_in ^ ~phase[PHASE_W-1], phase[PHASE_W-2:0]}));
      neg_r[0] <= neg_in;
    end
  end

  // Each stage performs four micro-rotations.
  for (genvar g = 0; g < CORDIC_STG; g++) begin : g_stg
    cordic_t x_nxt, y_nxt, z_nxt;

    always_comb begin
      cordic_t dx, dy;
      x_nxt = x_r[g];
      y_nxt = y_r[g];
      z_nxt = z_r[g];
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        dx = y_nxt >>> (g * STEPS_PER_STG + j);
        dy = x_nxt >>> (g * STEPS_PER_STG + j);
        if (!z_nxt[CORDIC_W-1]) begin
          x_nxt = x_nxt - dx;
          y_nxt = y_nxt + dy;
          z_nxt = z_nxt - ATAN_TAB[g * STEPS_PER_STG + j];
        end else begin
          x_nxt = x_nxt + dx;
          y_nxt = y_nxt - dy;
          z_nxt = z_nxt + ATAN_TAB[g * STEPS_PER_STG + j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g+1]   <= x_nxt;
        y_r[g+1]   <= y_nxt;
        z_r[g+1]   <= z_nxt;
        neg_r[g+1] <= neg_r[g];
      end
    end
  end

  // Round Q3.30 to Q1.16, clamp to one, and undo the quadrant fold.
  always_comb begin
    cordic_t cs, sn;
    cs = (x_r[CORDIC_STG] + CORDIC_W'(CORDIC_RND)) >>> CORDIC_SHIFT;
    sn = (y_r[CORDIC_STG] + CORDIC_W'(CORDIC_RND)) >>> CORDIC_SHIFT;
    if (cs > CORDIC_W'(TRIG_ONE))  cs = CORDIC_W'(TRIG_ONE);
    if (cs < -CORDIC_W'(TRIG_ONE)) cs = -CORDIC_W'(TRIG_ONE);
    if (sn > CORDIC_W'(TRIG_ONE))  sn = CORDIC_W'(TRIG_ONE);
    if (sn < -CORDIC_W'(TRIG_ONE)) sn = -CORDIC_W'(TRIG_ONE);
    if (neg_r[CORDIC_STG]) begin
      cs = -cs;
      sn = -sn;
    end
    cos_nxt = TRIG_W'(cs);
    sin_nxt = TRIG_W'(sn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

// ===== design/erv_rot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erv_rot
// Plane rotation (a, b) -> (a*c - b*s, a*s + b*c), rounded, with registered products and result.
// ----------------------------------------------------------------------------
module erv_rot import erv_pkg::*; #(
  parameter int IN_W = 33
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IN_W-1:0] a,
  input  logic signed [IN_W-1:0] b,
  input  trig_t                  c,
  input  trig_t                  s,
  output logic signed [IN_W+1:0] u,
  output logic signed [IN_W+1:0] w
);

  localparam int PW = IN_W + TRIG_W;
  localparam int SW = PW + 1;
  localparam int OW = IN_W + 2;

  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [SW-1:0] su, sw;
  logic signed [OW-1:0] u_r, w_r;

  // Stage one: four products.
  always_ff @(posedge clk) begin
    if (en) begin
      ac_r <= PW'(a) * PW'(c);
      bs_r <= PW'(b) * PW'(s);
      as_r <= PW'(a) * PW'(s);
      bc_r <= PW'(b) * PW'(c);
    end
  end

  // Stage two: sum, round half up, drop the fraction.
  assign su = SW'(ac_r) - SW'(bs_r) + SW'(1 << (TRIG_FRAC - 1));
  assign sw = SW'(as_r) + SW'(bc_r) + SW'(1 << (TRIG_FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= OW'(su >>> TRIG_FRAC);
      w_r <= OW'(sw >>> TRIG_FRAC);
    end
  end

  assign u = u_r;
  assign w = w_r;

endmodule

// ===== design/euler_rotate_vector.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless stalled; the fifteen stages share one enable.
// The whole pipeline holds only while the output register is valid and stalled.
// Reset clears the valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
// euler_rotate_vector
// Rotates a point about a pivot by roll, pitch and yaw angles (X, Y, Z order).
// ----------------------------------------------------------------------------
module euler_rotate_vector import erv_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [COORD_WIDTH-1:0] in_vec_y,
  input  logic signed [COORD_WIDTH-1:0] in_vec_z,
  input  logic signed [COORD_WIDTH-1:0] in_pivot_x,
  input  logic signed [COORD_WIDTH-1:0] in_pivot_y,
  input  logic signed [COORD_WIDTH-1:0] in_pivot_z,
  input  logic        [ANGLE_WIDTH-1:0] in_yaw_angle,
  input  logic        [ANGLE_WIDTH-1:0] in_pitch_angle,
  input  logic        [ANGLE_WIDTH-1:0] in_roll_angle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_rot_x,
  output logic signed [COORD_WIDTH-1:0] out_rot_y,
  output logic signed [COORD_WIDTH-1:0] out_rot_z
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int R1     = DW + 2;
  localparam int R2     = DW + 4;
  localparam int R3     = DW + 6;
  localparam int FW     = R3 + 1;
  localparam int NSTG   = 15;
  localparam int TRIG_S = CORDIC_STG + 2;
  localparam int PIT_S  = TRIG_S + 2;
  localparam int YAW_S  = TRIG_S + 4;
  localparam int OUT_S  = YAW_S + 2;

  logic                          en;
  logic                          v_r [NSTG];
  logic signed [DW-1:0]          dx_r [PIT_S];
  logic signed [DW-1:0]          dy_r [TRIG_S];
  logic signed [DW-1:0]          dz_r [TRIG_S];
  logic signed [COORD_WIDTH-1:0] px_r [OUT_S];
  logic signed [COORD_WIDTH-1:0] py_r [OUT_S];
  logic signed [COORD_WIDTH-1:0] pz_r [OUT_S];
  trig_t                         sy, cy, sp, cp, sr, cr;
  trig_t                         sp_r [2];
  trig_t                         cp_r [2];
  trig_t                         sy_r [4];
  trig_t                         cy_r [4];
  logic signed [R1-1:0]          y1, z1;
  logic signed [R1-1:0]          y1_r [2];
  logic signed [R2-1:0]          z2, x2;
  logic signed [R2-1:0]          z2_r [2];
  logic signed [R3-1:0]          x3, y3;
  logic signed [FW-1:0]          fx, fy, fz;
  logic signed [COORD_WIDTH-1:0] rx_r, ry_r, rz_r;
  logic signed [COORD_WIDTH-1:0] rx_nxt, ry_nxt, rz_nxt;

  // The pipeline advances unless a finished transaction waits at the output.
  assign en       = !(v_r[NSTG-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Pivot subtraction and the coordinate and pivot delay lines.
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= DW'(in_vec_x) - DW'(in_pivot_x);
      dy_r[0] <= DW'(in_vec_y) - DW'(in_pivot_y);
      dz_r[0] <= DW'(in_vec_z) - DW'(in_pivot_z);
      px_r[0] <= in_pivot_x;
      py_r[0] <= in_pivot_y;
      pz_r[0] <= in_pivot_z;
      for (int i = 1; i < PIT_S; i++) dx_r[i] <= dx_r[i-1];
      for (int i = 1; i < TRIG_S; i++) begin
        dy_r[i] <= dy_r[i-1];
        dz_r[i] <= dz_r[i-1];
      end
      for (int i = 1; i < OUT_S; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
    end
  end

  // Sine and cosine of the three angles.
  erv_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_yaw (
    .clk(clk), .en(en), .angle(in_yaw_angle), .sin_val(sy), .cos_val(cy)
  );
  erv_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_pitch (
    .clk(clk), .en(en), .angle(in_pitch_angle), .sin_val(sp), .cos_val(cp)
  );
  erv_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_roll (
    .clk(clk), .en(en), .angle(in_roll_angle), .sin_val(sr), .cos_val(cr)
  );

  // Hold pitch and yaw trig values until their rotation stage.
  always_ff @(posedge clk) begin
    if (en) begin
      sp_r[0] <= sp;
      cp_r[0] <= cp;
      sp_r[1] <= sp_r[0];
      cp_r[1] <= cp_r[0];
      sy_r[0] <= sy;
      cy_r[0] <= cy;
      for (int i = 1; i < 4; i++) begin
        sy_r[i] <= sy_r[i-1];
        cy_r[i] <= cy_r[i-1];
      end
    end
  end

  // Roll about X: (y, z).
  erv_rot #(.IN_W(DW)) u_roll (
    .clk(clk), .en(en), .a(dy_r[TRIG_S-1]), .b(dz_r[TRIG_S-1]),
    .c(cr), .s(sr), .u(y1), .w(z1)
  );

  // Pitch about Y: (z, x).
  erv_rot #(.IN_W(R1)) u_pitch (
    .clk(clk), .en(en), .a(z1), .b(R1'(dx_r[PIT_S-1])),
    .c(cp_r[1]), .s(sp_r[1]), .u(z2), .w(x2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      y1_r[0] <= y1;
      y1_r[1] <= y1_r[0];
      z2_r[0] <= z2;
      z2_r[1] <= z2_r[0];
    end
  end

  // Yaw about Z: (x, y).
  erv_rot #(.IN_W(R2)) u_yaw (
    .clk(clk), .en(en), .a(x2), .b(R2'(y1_r[1])),
    .c(cy_r[3]), .s(sy_r[3]), .u(x3), .w(y3)
  );

  // Add the pivot back and saturate to the coordinate width.
  assign fx = FW'(x3) + FW'(px_r[OUT_S-1]);
  assign fy = FW'(y3) + FW'(py_r[OUT_S-1]);
  assign fz = FW'(z2_r[1]) + FW'(pz_r[OUT_S-1]);

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] hi;
    logic signed [FW-1:0] lo;
    hi = FW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - FW'(1);
    if (v > hi)      sat = COORD_WIDTH'(hi);
    else if (v < lo) sat = COORD_WIDTH'(lo);
    else             sat = COORD_WIDTH'(v);
  endfunction

  assign rx_nxt = sat(fx);
  assign ry_nxt = sat(fy);
  assign rz_nxt = sat(fz);

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      rz_r <= rz_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_rot_x = rx_r;
  assign out_rot_y = ry_r;
  assign out_rot_z = rz_r;

endmodule

// ===== design/erv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erv_checker
// Port-level checks on the rotation pipeline handshake and flow control.
// ----------------------------------------------------------------------------
module erv_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COORD_WIDTH-1:0] out_rot_x
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side stalls only behind a stalled, valid result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result stays valid and its X coordinate stays stable.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rot_x)))
    else $error("stalled result changed or dropped");

  // A taken result never blocks the input in the same cycle.
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("input stalled while result was taken");

endmodule

bind euler_rotate_vector erv_checker #(.COORD_WIDTH(COORD_WIDTH)) u_erv_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_rot_x(out_rot_x)
);
